// ----- design/fesg_pkg.sv -----
// Shared types and constants for the filled ellipse span generator.
`timescale 1ns / 1ps

package fesg_pkg;

  // Default geometry widths
  localparam int COORD_BITS_DEF = 12;
  localparam int AXIS_BITS_DEF  = 11;

  // Error term wraps at this width
  localparam int ERR_BITS = 24;

  // Up to five primitives per input word, count fits in three bits
  localparam int MAX_RES = 5;
  localparam int CNT_W   = 3;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    PRIM_SPAN  = 1'b0,
    PRIM_POINT = 1'b1
  } prim_t;

  // Per-primitive control bits handed from the step unit to the output queue
  typedef struct packed {
    prim_t kind;
    logic  done;
  } res_ctl_t;

endpackage

// ----- design/filled_ellipse_span_generator_top.sv -----
// The first primitive of an input word is on the output the cycle after the word is taken.
// Throughput: one input word per cycle while words yield no primitives and no bundle waits;
// a word that yields n primitives (up to five) holds the input until its last one is taken,
// as the bundle register sends one primitive per cycle while out_tready is high.
// Reset (rst_n low, synchronous) leaves the tracer idle with no output pending.
`timescale 1ns / 1ps

module filled_ellipse_span_generator_top import fesg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF,
  localparam int IN_W  = ((2 * COORD_BITS + 2 * AXIS_BITS + 9 + 7) / 8) * 8,
  localparam int OUT_W = ((3 * (COORD_BITS + 2) + 9 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // center_row, center_col, semi_x, semi_y, draw_color, xor_mode (low to high)
  input  logic [IN_W-1:0]  in_tdata,
  // opcode
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // row_top, row_bottom, column, out_color, out_xor (low to high)
  output logic [OUT_W-1:0] out_tdata,
  // prim_kind, figure_done (low to high)
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  localparam int C  = COORD_BITS;
  localparam int A  = AXIS_BITS;
  localparam int OW = COORD_BITS + 2;

  logic                        in_fire;
  op_t                         in_op;
  logic [C-1:0]                in_center_row, in_center_col;
  logic [A-1:0]                in_semi_x, in_semi_y;
  logic [7:0]                  in_color;
  logic                        in_xor;

  logic [CNT_W-1:0]            res_cnt;
  res_ctl_t [MAX_RES-1:0]      res_ctl;
  logic [MAX_RES-1:0][OW-1:0]  res_top, res_bot, res_col;
  logic [7:0]                  res_color;
  logic                        res_xor;
  logic                        active;

  res_ctl_t                    o_ctl;
  logic [OW-1:0]               o_top, o_bot, o_col;
  logic [7:0]                  o_color;
  logic                        o_xor;

  // Input word unpack
  assign in_fire       = in_tvalid && in_tready;
  assign in_op         = op_t'(in_tuser);
  assign in_center_row = in_tdata[C-1:0];
  assign in_center_col = in_tdata[2*C-1:C];
  assign in_semi_x     = in_tdata[2*C+A-1:2*C];
  assign in_semi_y     = in_tdata[2*C+2*A-1:2*C+A];
  assign in_color      = in_tdata[2*C+2*A+7:2*C+2*A];
  assign in_xor        = in_tdata[2*C+2*A+8];

  fesg_step #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .opcode     (in_op),
    .center_row (in_center_row),
    .center_col (in_center_col),
    .semi_x     (in_semi_x),
    .semi_y     (in_semi_y),
    .draw_color (in_color),
    .xor_mode   (in_xor),
    .res_cnt    (res_cnt),
    .res_ctl    (res_ctl),
    .res_top    (res_top),
    .res_bot    (res_bot),
    .res_col    (res_col),
    .res_color  (res_color),
    .res_xor    (res_xor),
    .active     (active)
  );

  fesg_outq #(
    .COORD_BITS (COORD_BITS)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .res_cnt    (res_cnt),
    .res_ctl    (res_ctl),
    .res_top    (res_top),
    .res_bot    (res_bot),
    .res_col    (res_col),
    .res_color  (res_color),
    .res_xor    (res_xor),
    .can_load   (in_tready),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_ctl    (o_ctl),
    .out_top    (o_top),
    .out_bot    (o_bot),
    .out_col    (o_col),
    .out_color  (o_color),
    .out_xor    (o_xor),
    .out_last   (out_tlast)
  );

  // Output word pack
  assign out_tdata = OUT_W'({o_xor, o_color, o_col, o_bot, o_top});
  assign out_tuser = {o_ctl.done, o_ctl.kind};

  // The closing span is always a span and always ends its word's run
  a_done_is_last_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && (out_tuser[0] == PRIM_SPAN))
    else $error("figure_done word is not a final span");

  // Once the closing span is out, the tracer has already gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[1] |-> !active)
    else $error("tracer still active at figure_done");

  // A start with a nonzero axis shows its first span the next cycle
  a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == OP_START) && (in_semi_x != '0 || in_semi_y != '0)
    |=> out_tvalid && (out_tuser[0] == PRIM_SPAN))
    else $error("start word produced no span");

  // Points never carry the figure end flag
  a_point_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == PRIM_POINT) |-> !out_tuser[1])
    else $error("point marked as figure end");

endmodule

// ----- design/fesg_step.sv -----
// Ellipse trace state and one-word step logic that builds a bundle of primitives.
`timescale 1ns / 1ps

module fesg_step import fesg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_fire,
  input  op_t                                    opcode,
  input  logic [COORD_BITS-1:0]                  center_row,
  input  logic [COORD_BITS-1:0]                  center_col,
  input  logic [AXIS_BITS-1:0]                   semi_x,
  input  logic [AXIS_BITS-1:0]                   semi_y,
  input  logic [7:0]                             draw_color,
  input  logic                                   xor_mode,
  output logic [CNT_W-1:0]                       res_cnt,
  output res_ctl_t [MAX_RES-1:0]                 res_ctl,
  output logic [MAX_RES-1:0][COORD_BITS+1:0]     res_top,
  output logic [MAX_RES-1:0][COORD_BITS+1:0]     res_bot,
  output logic [MAX_RES-1:0][COORD_BITS+1:0]     res_col,
  output logic [7:0]                             res_color,
  output logic                                   res_xor,
  output logic                                   active
);

  localparam int OW = COORD_BITS + 2;
  localparam int PW = AXIS_BITS + 1;
  localparam int IW = AXIS_BITS + 3;
  localparam int CW = ((COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS) + 3;

  // base +/- signed offset, wrapped to the output width
  function automatic logic [OW-1:0] offs(input logic [COORD_BITS-1:0] base,
                                         input logic [PW-1:0] off,
                                         input logic sub);
    logic signed [CW-1:0] b_w;
    logic signed [CW-1:0] o_w;
    logic signed [CW-1:0] s_w;
    b_w = $signed({{(CW-COORD_BITS){1'b0}}, base});
    o_w = $signed({{(CW-PW){off[PW-1]}}, off});
    s_w = sub ? (b_w - o_w) : (b_w + o_w);
    return s_w[OW-1:0];
  endfunction

  // State registers
  logic                        active_r, active_nxt;
  logic [COORD_BITS-1:0]       ctr_row_r, ctr_row_nxt;
  logic [COORD_BITS-1:0]       ctr_col_r, ctr_col_nxt;
  logic [AXIS_BITS-1:0]        axis_a_r, axis_a_nxt;
  logic [AXIS_BITS-1:0]        axis_b_r, axis_b_nxt;
  logic [AXIS_BITS-1:0]        radius_r, radius_nxt;
  logic [PW-1:0]               pos_x_r, pos_x_nxt;
  logic [PW-1:0]               pos_y_r, pos_y_nxt;
  logic [PW-1:0]               acc_x_r, acc_x_nxt;
  logic [PW-1:0]               acc_y_r, acc_y_nxt;
  logic signed [ERR_BITS-1:0]  err_r, err_nxt;
  logic signed [IW-1:0]        inc_x_r, inc_x_nxt;
  logic signed [IW-1:0]        inc_y_r, inc_y_nxt;
  logic                        neg_x_r, neg_x_nxt;
  logic                        neg_y_r, neg_y_nxt;
  logic [PW-1:0]               steps_r, steps_nxt;
  logic [7:0]                  color_r, color_nxt;
  logic                        xor_r, xor_nxt;

  // Step datapath temporaries
  logic                        emit_pair, emit_pts, emit_fin;
  logic [PW:0]                 acc_sum, acc_diff;
  logic signed [ERR_BITS-1:0]  err_step;
  logic signed [IW-1:0]        inc_new;
  logic                        flip;
  logic [OW-1:0]               row_m, row_p, col_p, col_m, fin_top, fin_bot;
  logic [CNT_W-1:0]            n;

  // Next state for a start or one trace iteration
  always_comb begin
    active_nxt  = active_r;
    ctr_row_nxt = ctr_row_r;
    ctr_col_nxt = ctr_col_r;
    axis_a_nxt  = axis_a_r;
    axis_b_nxt  = axis_b_r;
    radius_nxt  = radius_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    acc_x_nxt   = acc_x_r;
    acc_y_nxt   = acc_y_r;
    err_nxt     = err_r;
    inc_x_nxt   = inc_x_r;
    inc_y_nxt   = inc_y_r;
    neg_x_nxt   = neg_x_r;
    neg_y_nxt   = neg_y_r;
    steps_nxt   = steps_r;
    color_nxt   = color_r;
    xor_nxt     = xor_r;
    emit_pair   = 1'b0;
    emit_pts    = 1'b0;
    emit_fin    = 1'b0;
    acc_sum     = '0;
    acc_diff    = '0;
    err_step    = '0;
    inc_new     = '0;
    flip        = 1'b0;

    if (in_fire) begin
      if (opcode == OP_START) begin
        if (semi_x == '0 && semi_y == '0) begin
          active_nxt = 1'b0;
        end else begin
          ctr_row_nxt = center_row;
          ctr_col_nxt = center_col;
          axis_a_nxt  = semi_x;
          axis_b_nxt  = semi_y;
          radius_nxt  = (semi_x < semi_y) ? semi_y : semi_x;
          color_nxt   = draw_color;
          xor_nxt     = xor_mode;
          neg_x_nxt   = 1'b1;
          neg_y_nxt   = 1'b0;
          acc_x_nxt   = '0;
          acc_y_nxt   = '0;
          err_nxt     = '0;
          inc_x_nxt   = IW'(1) - {2'b00, radius_nxt, 1'b0};
          inc_y_nxt   = IW'(1);
          pos_x_nxt   = {1'b0, semi_x};
          pos_y_nxt   = '0;
          steps_nxt   = {radius_nxt, 1'b0} - PW'(1);
          active_nxt  = 1'b1;
          emit_pair   = 1'b1;
        end
      end else if (active_r) begin
        if (!err_r[ERR_BITS-1]) begin
          // x move of the circle
          acc_sum  = {1'b0, acc_x_r} + {2'b00, axis_a_r};
          acc_diff = acc_sum - {2'b00, radius_r};
          if (acc_sum >= {2'b00, radius_r}) begin
            pos_x_nxt = neg_x_r ? (pos_x_r - PW'(1)) : (pos_x_r + PW'(1));
            acc_x_nxt = acc_diff[PW-1:0];
            emit_pair = 1'b1;
          end else begin
            acc_x_nxt = acc_sum[PW-1:0];
          end
          if (!inc_x_r[IW-1] && inc_x_r != '0)
            err_step = err_r - {{(ERR_BITS-IW){inc_x_r[IW-1]}}, inc_x_r};
          else
            err_step = err_r + {{(ERR_BITS-IW){inc_x_r[IW-1]}}, inc_x_r};
          inc_new   = inc_x_r + IW'(2);
          inc_x_nxt = inc_new;
          flip      = (inc_new == '0) || (inc_new == IW'(1));
          if (flip) begin
            neg_y_nxt = ~neg_y_r;
            inc_y_nxt = IW'(2) - inc_y_r;
            err_nxt   = -err_step;
          end else begin
            err_nxt   = err_step;
          end
        end else begin
          // y move of the circle
          acc_sum  = {1'b0, acc_y_r} + {2'b00, axis_b_r};
          acc_diff = acc_sum - {2'b00, radius_r};
          if (acc_sum >= {2'b00, radius_r}) begin
            pos_y_nxt = neg_y_r ? (pos_y_r - PW'(1)) : (pos_y_r + PW'(1));
            acc_y_nxt = acc_diff[PW-1:0];
            emit_pts  = 1'b1;
          end else begin
            acc_y_nxt = acc_sum[PW-1:0];
          end
          if (!inc_y_r[IW-1] && inc_y_r != '0)
            err_step = err_r + {{(ERR_BITS-IW){inc_y_r[IW-1]}}, inc_y_r};
          else
            err_step = err_r - {{(ERR_BITS-IW){inc_y_r[IW-1]}}, inc_y_r};
          inc_new   = inc_y_r + IW'(2);
          inc_y_nxt = inc_new;
          flip      = (inc_new == '0) || (inc_new == IW'(1));
          if (flip) begin
            neg_x_nxt = ~neg_x_r;
            inc_x_nxt = IW'(2) - inc_x_r;
            err_nxt   = -err_step;
          end else begin
            err_nxt   = err_step;
          end
        end
        // iteration count, final center span ends the figure
        if (steps_r <= PW'(1)) begin
          steps_nxt  = '0;
          emit_fin   = 1'b1;
          active_nxt = 1'b0;
        end else begin
          steps_nxt  = steps_r - PW'(1);
        end
      end
    end
  end

  // Mirrored coordinates, taken from the updated position
  always_comb begin
    row_m   = offs(ctr_row_nxt, pos_y_nxt, 1'b1);
    row_p   = offs(ctr_row_nxt, pos_y_nxt, 1'b0);
    col_p   = offs(ctr_col_nxt, pos_x_nxt, 1'b0);
    col_m   = offs(ctr_col_nxt, pos_x_nxt, 1'b1);
    fin_top = offs(ctr_row_nxt, {1'b0, axis_b_nxt}, 1'b1);
    fin_bot = offs(ctr_row_nxt, {1'b0, axis_b_nxt}, 1'b0);
  end

  // Bundle of primitives in emission order
  always_comb begin
    n       = '0;
    res_ctl = '0;
    res_top = '0;
    res_bot = '0;
    res_col = '0;
    if (emit_pair) begin
      res_ctl[0] = '{kind: PRIM_SPAN, done: 1'b0};
      res_top[0] = row_m;
      res_bot[0] = row_p;
      res_col[0] = col_p;
      res_ctl[1] = '{kind: PRIM_SPAN, done: 1'b0};
      res_top[1] = row_m;
      res_bot[1] = row_p;
      res_col[1] = col_m;
      n = CNT_W'(2);
    end
    if (emit_pts) begin
      res_ctl[0] = '{kind: PRIM_POINT, done: 1'b0};
      res_top[0] = row_m;
      res_bot[0] = row_m;
      res_col[0] = col_p;
      res_ctl[1] = '{kind: PRIM_POINT, done: 1'b0};
      res_top[1] = row_p;
      res_bot[1] = row_p;
      res_col[1] = col_p;
      res_ctl[2] = '{kind: PRIM_POINT, done: 1'b0};
      res_top[2] = row_m;
      res_bot[2] = row_m;
      res_col[2] = col_m;
      res_ctl[3] = '{kind: PRIM_POINT, done: 1'b0};
      res_top[3] = row_p;
      res_bot[3] = row_p;
      res_col[3] = col_m;
      n = CNT_W'(4);
    end
    if (emit_fin) begin
      res_ctl[n] = '{kind: PRIM_SPAN, done: 1'b1};
      res_top[n] = fin_top;
      res_bot[n] = fin_bot;
      res_col[n] = OW'(ctr_col_nxt);
      n = n + CNT_W'(1);
    end
  end

  assign res_cnt   = n;
  assign res_color = color_nxt;
  assign res_xor   = xor_nxt;
  assign active    = active_r;

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      ctr_row_r <= '0;
      ctr_col_r <= '0;
      axis_a_r  <= '0;
      axis_b_r  <= '0;
      radius_r  <= '0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      acc_x_r   <= '0;
      acc_y_r   <= '0;
      err_r     <= '0;
      inc_x_r   <= '0;
      inc_y_r   <= '0;
      neg_x_r   <= 1'b1;
      neg_y_r   <= 1'b0;
      steps_r   <= '0;
      color_r   <= '0;
      xor_r     <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      ctr_row_r <= ctr_row_nxt;
      ctr_col_r <= ctr_col_nxt;
      axis_a_r  <= axis_a_nxt;
      axis_b_r  <= axis_b_nxt;
      radius_r  <= radius_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      acc_x_r   <= acc_x_nxt;
      acc_y_r   <= acc_y_nxt;
      err_r     <= err_nxt;
      inc_x_r   <= inc_x_nxt;
      inc_y_r   <= inc_y_nxt;
      neg_x_r   <= neg_x_nxt;
      neg_y_r   <= neg_y_nxt;
      steps_r   <= steps_nxt;
      color_r   <= color_nxt;
      xor_r     <= xor_nxt;
    end
  end

endmodule

// ----- design/fesg_outq.sv -----
// Result register holding one bundle of primitives, sent out one word per cycle while out_ready is high.
`timescale 1ns / 1ps

module fesg_outq import fesg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_fire,
  input  logic [CNT_W-1:0]                    res_cnt,
  input  res_ctl_t [MAX_RES-1:0]              res_ctl,
  input  logic [MAX_RES-1:0][COORD_BITS+1:0]  res_top,
  input  logic [MAX_RES-1:0][COORD_BITS+1:0]  res_bot,
  input  logic [MAX_RES-1:0][COORD_BITS+1:0]  res_col,
  input  logic [7:0]                          res_color,
  input  logic                                res_xor,
  output logic                                can_load,
  input  logic                                out_ready,
  output logic                                out_valid,
  output res_ctl_t                            out_ctl,
  output logic [COORD_BITS+1:0]               out_top,
  output logic [COORD_BITS+1:0]               out_bot,
  output logic [COORD_BITS+1:0]               out_col,
  output logic [7:0]                          out_color,
  output logic                                out_xor,
  output logic                                out_last
);

  localparam int OW = COORD_BITS + 2;

  logic                          valid_r, valid_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  res_ctl_t [MAX_RES-1:0]        ctl_r;
  logic [MAX_RES-1:0][OW-1:0]    top_r, bot_r, col_r;
  logic [7:0]                    color_r;
  logic                          xor_r;
  logic                          at_last;
  logic                          load;

  assign at_last  = (idx_r == cnt_r - CNT_W'(1));
  assign can_load = !valid_r || (out_ready && at_last);
  assign load     = in_fire && (res_cnt != '0);

  // Bundle control: load, advance, drain
  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      cnt_nxt   = res_cnt;
      idx_nxt   = '0;
    end else if (valid_r && out_ready) begin
      if (at_last)
        valid_nxt = 1'b0;
      else
        idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Bundle payload
  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r   <= res_ctl;
      top_r   <= res_top;
      bot_r   <= res_bot;
      col_r   <= res_col;
      color_r <= res_color;
      xor_r   <= res_xor;
    end
  end

  // Word select
  assign out_valid = valid_r;
  assign out_ctl   = ctl_r[idx_r];
  assign out_top   = top_r[idx_r];
  assign out_bot   = bot_r[idx_r];
  assign out_col   = col_r[idx_r];
  assign out_color = color_r;
  assign out_xor   = xor_r;
  assign out_last  = at_last;

endmodule
